// ===== hw/rtl/svps_pkg.sv =====
package svps_pkg;

    // valve line layout of the sampler board
    localparam int NUM_LINES         = 32;
    localparam int FIRST_SAMPLE_LINE = 1;
    localparam int FLUSH_LINE        = 0;

    localparam int TICK_W   = 16;
    localparam int INDEX_W  = 5;
    localparam int LINE_W   = 5;
    // wide enough for first sample line plus the largest index, and for NUM_LINES
    localparam int CALC_W   = 7;
    localparam logic [INDEX_W-1:0] INDEX_MAX = {INDEX_W{1'b1}};

    typedef enum logic [2:0] {
        PH_SETUP    = 3'd0,
        PH_IDLE     = 3'd1,
        PH_PURGE    = 3'd2,
        PH_FLUSH    = 3'd3,
        PH_SAMPLE   = 3'd4,
        PH_STOP     = 3'd5,
        PH_FINISHED = 3'd6
    } phase_t;

    // configuration register indexes
    localparam logic [2:0] CFG_SETUP_TICKS  = 3'd0;
    localparam logic [2:0] CFG_IDLE_TICKS   = 3'd1;
    localparam logic [2:0] CFG_PURGE_TICKS  = 3'd2;
    localparam logic [2:0] CFG_FLUSH_TICKS  = 3'd3;
    localparam logic [2:0] CFG_SAMPLE_TICKS = 3'd4;
    localparam logic [2:0] CFG_VALVE_COUNT  = 3'd5;

    typedef struct packed {
        logic              done_res;
        logic              pump_reverse;
        logic              pump_on;
        logic [LINE_W-1:0] valve_line;
        logic              valve_on;
        logic [2:0]        phase;
    } drive_t;

endpackage

// ===== hw/rtl/svps_drive.sv =====
module svps_drive
    import svps_pkg::*;
(
    input  phase_t             phase,
    input  logic [INDEX_W-1:0] valve_index,
    output drive_t             drive
);

    logic [CALC_W-1:0] sample_line;
    logic [CALC_W-1:0] line;
    logic              line_ok;

    assign sample_line = CALC_W'(FIRST_SAMPLE_LINE) + CALC_W'(valve_index);

    always_comb
    begin
        drive              = '0;
        drive.phase        = phase;
        drive.done_res     = (phase == PH_FINISHED);
        line               = sample_line;
        case (phase)
            PH_PURGE:
            begin
                drive.pump_on      = 1'b1;
                drive.pump_reverse = 1'b1;
            end
            PH_FLUSH:
            begin
                line          = CALC_W'(FLUSH_LINE);
                drive.pump_on = 1'b1;
            end
            PH_SAMPLE:
            begin
                drive.pump_on = 1'b1;
            end
            default:
            begin
                drive.pump_on = 1'b0;
            end
        endcase
        // lines past the board or the 5-bit field drive nothing
        line_ok = (line < CALC_W'(NUM_LINES)) && (line <= CALC_W'(31));
        if (drive.pump_on && line_ok)
        begin
            drive.valve_on   = 1'b1;
            drive.valve_line = line[LINE_W-1:0];
        end
    end

endmodule

// ===== hw/rtl/sampler_valve_pump_sequencer_unit.sv =====
// Timed valve and pump sequencer for a multi-valve water sampler. Each transfer on the
// input stream carries one tick bit: 1 lets one time unit pass, 0 only reports. Every
// input transfer yields exactly one output transfer showing the state after the update:
// phase, driven valve line, pump on and direction, and the done flag. Phases run setup,
// purge (sample valve, pump reversed), flush (flush valve, pump forward), sample (sample
// valve, pump forward), then straight through stop to idle or, when all valves are taken,
// to finished, which holds. A phase loaded with T ticks ends on its T-th tick; zero acts
// as one. Sequencer state updates at the input transfer and the result lands in a single
// output register, so a new item is taken every cycle while the output side keeps up.
// Duration writes take effect at the next entry to their phase (setup's is never read);
// the user must write configuration only while the stream is idle; this is unenforced.
module sampler_valve_pump_sequencer_unit
    import svps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] tick, [7:1] zero

    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [2:0] phase, [3] valve_on, [8:4] valve_line,
                                        // [9] pump_on, [10] pump_reverse, [11] done_res,
                                        // [15:12] zero

    // configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_data
);

    // configuration registers
    logic [TICK_W-1:0]  setup_ticks_reg;
    logic [TICK_W-1:0]  idle_ticks_reg;
    logic [TICK_W-1:0]  purge_ticks_reg;
    logic [TICK_W-1:0]  flush_ticks_reg;
    logic [TICK_W-1:0]  sample_ticks_reg;
    logic [INDEX_W-1:0] valve_count_reg;

    // sequencer state
    phase_t             phase_reg, phase_next;
    logic [TICK_W-1:0]  countdown_reg, countdown_next;
    logic [INDEX_W-1:0] valve_index_reg, valve_index_next;
    logic [INDEX_W-1:0] index_inc;

    // result register
    logic               out_valid_reg;
    drive_t             result_reg;
    drive_t             result_next;

    logic               in_xfer;
    logic               tick;

    assign tick          = s_axis_tdata[0];
    // the output register is free, or is being emptied this cycle
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setup_ticks_reg  <= TICK_W'(1);
            idle_ticks_reg   <= TICK_W'(1);
            purge_ticks_reg  <= TICK_W'(1);
            flush_ticks_reg  <= TICK_W'(1);
            sample_ticks_reg <= TICK_W'(1);
            valve_count_reg  <= INDEX_W'(24);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_SETUP_TICKS:  setup_ticks_reg  <= cfg_data;
                CFG_IDLE_TICKS:   idle_ticks_reg   <= cfg_data;
                CFG_PURGE_TICKS:  purge_ticks_reg  <= cfg_data;
                CFG_FLUSH_TICKS:  flush_ticks_reg  <= cfg_data;
                CFG_SAMPLE_TICKS: sample_ticks_reg <= cfg_data;
                CFG_VALVE_COUNT:  valve_count_reg  <= cfg_data[INDEX_W-1:0];
                default:          ;
            endcase
        end
    end

    // valve index saturates at its top value
    assign index_inc = (valve_index_reg != INDEX_MAX) ? valve_index_reg + INDEX_W'(1)
                                                      : valve_index_reg;

    always_comb
    begin
        phase_next       = phase_reg;
        countdown_next   = countdown_reg;
        valve_index_next = valve_index_reg;
        if (tick && phase_reg != PH_FINISHED)
        begin
            if (countdown_reg > TICK_W'(1))
            begin
                countdown_next = countdown_reg - TICK_W'(1);
            end
            else
            begin
                case (phase_reg)
                    PH_SETUP, PH_IDLE:
                    begin
                        phase_next     = PH_PURGE;
                        countdown_next = purge_ticks_reg;
                    end
                    PH_PURGE:
                    begin
                        phase_next     = PH_FLUSH;
                        countdown_next = flush_ticks_reg;
                    end
                    PH_FLUSH:
                    begin
                        phase_next     = PH_SAMPLE;
                        countdown_next = sample_ticks_reg;
                    end
                    PH_SAMPLE:
                    begin
                        // stop is passed within this tick: pump off, valves closed
                        valve_index_next = index_inc;
                        if (index_inc < valve_count_reg)
                        begin
                            phase_next     = PH_IDLE;
                            countdown_next = idle_ticks_reg;
                        end
                        else
                        begin
                            phase_next     = PH_FINISHED;
                            countdown_next = '0;
                        end
                    end
                    default:
                    begin
                        phase_next     = PH_FINISHED;
                        countdown_next = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_SETUP;
            countdown_reg   <= TICK_W'(1);
            valve_index_reg <= '0;
        end
        else if (in_xfer)
        begin
            phase_reg       <= phase_next;
            countdown_reg   <= countdown_next;
            valve_index_reg <= valve_index_next;
        end
    end

    // decode of valve and pump drive from the updated state
    svps_drive u_drive (
        .phase       (phase_next),
        .valve_index (valve_index_next),
        .drive       (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            result_reg <= result_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, result_reg};

endmodule
